// ===== sv/filmic_tonemap_rgb8_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the filmic tone mapper
// Clocked, reset-gated property shorthands used by the checker.
// ---------------------------------------------------------------------------
`ifndef FILMIC_TONEMAP_RGB8_ASSERT_SVH
`define FILMIC_TONEMAP_RGB8_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define FTM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define FTM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/ftm_pkg.sv =====
// ---------------------------------------------------------------------------
// ftm_pkg
// Widths, curve constants and pipeline control type for the tone mapper.
// ---------------------------------------------------------------------------
`default_nettype none

package ftm_pkg;

  localparam int IN_W            = 24;
  localparam int INPUT_FRAC_BITS = 16;
  localparam int XW              = IN_W - 1;
  localparam int QW              = 8;

  // 0.004 in input units, rounded to nearest
  localparam logic [XW-1:0] OFFSET = XW'(((4 << INPUT_FRAC_BITS) + 500) / 1000);

  // bound the denominator: 310*X^2, 85*X*2^F and 3*2^2F, plus carries
  localparam int T_SQ   = 2 * XW + 9;
  localparam int T_LIN  = XW + INPUT_FRAC_BITS + 7;
  localparam int T_ONE  = 2 * INPUT_FRAC_BITS + 2;
  localparam int T_MAX0 = (T_SQ > T_LIN) ? T_SQ : T_LIN;
  localparam int T_MAX  = (T_MAX0 > T_ONE) ? T_MAX0 : T_ONE;
  localparam int DEN_W  = T_MAX + 2;
  localparam int RW     = DEN_W + QW;

  localparam logic [DEN_W-1:0] K_SQ   = DEN_W'(310);
  localparam logic [DEN_W-1:0] K_NUM  = DEN_W'(25);
  localparam logic [DEN_W-1:0] K_DIFF = DEN_W'(60);
  localparam logic [DEN_W-1:0] K_ONE2 = DEN_W'(3) << (2 * INPUT_FRAC_BITS);

  localparam int FRONT_N = 4;
  localparam int DIV_N   = QW;
  localparam int NSTG    = FRONT_N + DIV_N;

  typedef struct packed {
    logic [NSTG-1:0] en;
  } ftm_ctl_t;

endpackage

`default_nettype wire

// ===== sv/ftm_if.sv =====
// ---------------------------------------------------------------------------
// ftm_in_if / ftm_out_if
// Valid/ready channels for linear HDR pixels and RGB8 pixels.
// ---------------------------------------------------------------------------
`default_nettype none

interface ftm_in_if import ftm_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] red_linear;
  logic signed [IN_W-1:0] green_linear;
  logic signed [IN_W-1:0] blue_linear;

  modport source (output valid, red_linear, green_linear, blue_linear, input ready);
  modport sink   (input valid, red_linear, green_linear, blue_linear, output ready);
endinterface

interface ftm_out_if import ftm_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [QW-1:0] red_byte;
  logic [QW-1:0] green_byte;
  logic [QW-1:0] blue_byte;

  modport source (output valid, red_byte, green_byte, blue_byte, input ready);
  modport sink   (input valid, red_byte, green_byte, blue_byte, output ready);
endinterface

`default_nettype wire

// ===== sv/filmic_tonemap_rgb8.sv =====
// Filmic tone mapper: takes one linear HDR pixel (signed Q8.16 red, green,
// blue) per clock and returns one RGB8 pixel per clock while the output is
// not stalled, each channel mapped through x(6.2x+0.5)/(x(6.2x+1.7)+0.06)
// after a zero clamp and a 0.004 offset, then scaled by 255 and truncated.
// Four stages form the exact integer numerator and denominator (clamp,
// square, two adds) and eight stages run a restoring divider that
// produces one quotient bit each. Every stage has its own valid bit and
// loads whenever it is empty or its word moves on, so an output stall lets
// upstream bubbles fill before in ready drops.
// ---------------------------------------------------------------------------
// filmic_tonemap_rgb8
// Top level: shared pipeline control and three channel datapaths.
// ---------------------------------------------------------------------------
`default_nettype none

module filmic_tonemap_rgb8 import ftm_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  ftm_in_if.sink  in_px,
  ftm_out_if.source out_px
);

  ftm_ctl_t               ctl;
  logic signed [IN_W-1:0] lin [3];
  logic [RW-1:0]          num_scaled [3];
  logic [DEN_W-1:0]       den [3];
  logic [QW-1:0]          quo [3];

  ftm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_px.valid),
    .in_ready  (in_px.ready),
    .out_valid (out_px.valid),
    .out_ready (out_px.ready),
    .ctl       (ctl)
  );

  assign lin[0] = in_px.red_linear;
  assign lin[1] = in_px.green_linear;
  assign lin[2] = in_px.blue_linear;

  for (genvar c = 0; c < 3; c++) begin : g_chan
    ftm_curve u_curve (
      .clk        (clk),
      .ctl        (ctl),
      .lin        (lin[c]),
      .num_scaled (num_scaled[c]),
      .den        (den[c])
    );

    ftm_div u_div (
      .clk        (clk),
      .ctl        (ctl),
      .num_scaled (num_scaled[c]),
      .den        (den[c]),
      .quo        (quo[c])
    );
  end

  assign out_px.red_byte   = quo[0];
  assign out_px.green_byte = quo[1];
  assign out_px.blue_byte  = quo[2];

endmodule

`default_nettype wire

// ===== sv/ftm_ctrl.sv =====
// ---------------------------------------------------------------------------
// ftm_ctrl
// Per-stage valid bits and load enables; bubbles collapse under a stall.
// ---------------------------------------------------------------------------
`default_nettype none

module ftm_ctrl import ftm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output ftm_ctl_t ctl
);

  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] v_nxt;
  logic [NSTG:0]   en;

  // a stage loads when it is empty or its word moves on
  always_comb begin
    en[NSTG] = out_ready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  always_comb begin
    v_nxt[0] = en[0] ? in_valid : v_r[0];
    for (int k = 1; k < NSTG; k++) begin
      v_nxt[k] = en[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NSTG-1];
  assign ctl.en    = en[NSTG-1:0];

endmodule

`default_nettype wire

// ===== sv/ftm_curve.sv =====
// ---------------------------------------------------------------------------
// ftm_curve
// Clamp, offset and exact integer numerator/denominator of the curve.
// ---------------------------------------------------------------------------
`default_nettype none

module ftm_curve import ftm_pkg::*; (
  input  logic                   clk,
  input  ftm_ctl_t               ctl,
  input  logic signed [IN_W-1:0] lin,
  output logic [RW-1:0]          num_scaled,
  output logic [DEN_W-1:0]       den
);

  logic [XW-1:0]    x0_r, x0_nxt;
  logic [XW-1:0]    x1_r;
  logic [2*XW-1:0]  p1_r;
  logic [XW-1:0]    x2_r;
  logic [DEN_W-1:0] num2_r, num2_nxt;
  logic [DEN_W-1:0] den3_r, den3_nxt;
  logic [RW-1:0]    ns3_r, ns3_nxt;
  logic [DEN_W-1:0] xs1, xs2;

  // negative clamps to zero, then drop the offset and clamp again
  always_comb begin
    if (lin[IN_W-1] || (lin[XW-1:0] <= OFFSET)) begin
      x0_nxt = '0;
    end else begin
      x0_nxt = lin[XW-1:0] - OFFSET;
    end
  end

  assign xs1      = DEN_W'(x1_r) << INPUT_FRAC_BITS;
  assign xs2      = DEN_W'(x2_r) << INPUT_FRAC_BITS;
  assign num2_nxt = DEN_W'(p1_r) * K_SQ + xs1 * K_NUM;
  assign den3_nxt = num2_r + xs2 * K_DIFF + K_ONE2;
  // 255 * num
  assign ns3_nxt  = (RW'(num2_r) << QW) - RW'(num2_r);

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      x0_r <= x0_nxt;
    end
    if (ctl.en[1]) begin
      p1_r <= x0_r * x0_r;
      x1_r <= x0_r;
    end
    if (ctl.en[2]) begin
      num2_r <= num2_nxt;
      x2_r   <= x1_r;
    end
    if (ctl.en[3]) begin
      den3_r <= den3_nxt;
      ns3_r  <= ns3_nxt;
    end
  end

  assign num_scaled = ns3_r;
  assign den        = den3_r;

endmodule

`default_nettype wire

// ===== sv/ftm_div.sv =====
// ---------------------------------------------------------------------------
// ftm_div
// Restoring divider, one quotient bit per stage, MSB first.
// ---------------------------------------------------------------------------
`default_nettype none

module ftm_div import ftm_pkg::*; (
  input  logic             clk,
  input  ftm_ctl_t         ctl,
  input  logic [RW-1:0]    num_scaled,
  input  logic [DEN_W-1:0] den,
  output logic [QW-1:0]    quo
);

  logic [RW-1:0]    rem_r [DIV_N-1];
  logic [DEN_W-1:0] d_r   [DIV_N-1];
  logic [QW-1:0]    q_r   [DIV_N];

  for (genvar j = 0; j < DIV_N; j++) begin : g_step
    logic [RW-1:0]    rem_in;
    logic [DEN_W-1:0] d_in;
    logic [QW-1:0]    q_in;
    logic [RW-1:0]    dsh;
    logic             take;

    if (j == 0) begin : g_first
      assign rem_in = num_scaled;
      assign d_in   = den;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign d_in   = d_r[j-1];
      assign q_in   = q_r[j-1];
    end

    assign dsh  = RW'(d_in) << (DIV_N - 1 - j);
    assign take = (rem_in >= dsh);

    always_ff @(posedge clk) begin
      if (ctl.en[FRONT_N + j]) begin
        q_r[j] <= {q_in[QW-2:0], take};
      end
    end

    if (j < DIV_N - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (ctl.en[FRONT_N + j]) begin
          rem_r[j] <= take ? (rem_in - dsh) : rem_in;
          d_r[j]   <= d_in;
        end
      end
    end
  end

  assign quo = q_r[DIV_N-1];

endmodule

`default_nettype wire

// ===== sv/ftm_checker.sv =====
// ---------------------------------------------------------------------------
// ftm_checker
// Port-level checks on the tone mapper, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "filmic_tonemap_rgb8_assert.svh"

module ftm_checker import ftm_pkg::*; (
  input logic          clk,
  input logic          rst_n,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input logic [QW-1:0] red_byte,
  input logic [QW-1:0] green_byte,
  input logic [QW-1:0] blue_byte
);

  localparam logic [QW-1:0] BYTE_MAX = '1;

  // hold a stalled word
  `FTM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "out word dropped while stalled")
  `FTM_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(red_byte) && $stable(green_byte) && $stable(blue_byte), "out word changed while stalled")
  // a draining output frees every stage
  `FTM_ASSERT_SAME(a_in_ready, clk, rst_n, !out_valid || out_ready, in_ready, "input stalled with output draining")
  // the curve stays below one, so a byte never saturates
  `FTM_ASSERT_SAME(a_byte_range, clk, rst_n, out_valid, (red_byte != BYTE_MAX) && (green_byte != BYTE_MAX) && (blue_byte != BYTE_MAX), "byte reached full scale")

endmodule

bind filmic_tonemap_rgb8 ftm_checker u_ftm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_px.ready),
  .out_valid  (out_px.valid),
  .out_ready  (out_px.ready),
  .red_byte   (out_px.red_byte),
  .green_byte (out_px.green_byte),
  .blue_byte  (out_px.blue_byte)
);

`default_nettype wire

// ===== test/tonemap_check.sv =====
// ---------------------------------------------------------------------------
// tonemap_check
// Watches both pixel channels of the filmic tone mapper. For every accepted
// HDR word it predicts the RGB8 word exactly in wide integers, then compares
// each returned word in order and counts the failures.
// ---------------------------------------------------------------------------
`default_nettype none

module tonemap_check import ftm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  ftm_in_if    in_px,
  ftm_out_if   out_px,
  output int   errors,
  output int   pending
);

  localparam int AW = 72;
  localparam logic [AW-1:0] UNIT = AW'(1) << INPUT_FRAC_BITS;
  // 0.004 in input units, ties rounded up
  localparam logic [AW-1:0] TOE  = ((AW'(4) << INPUT_FRAC_BITS) + AW'(500)) / AW'(1000);

  typedef struct packed {
    logic [QW-1:0] red;
    logic [QW-1:0] green;
    logic [QW-1:0] blue;
  } rgb8_t;

  rgb8_t expected_px[$];

  // filmic curve on one channel: num/den are the curve terms scaled by 50*2^2F
  function automatic logic [QW-1:0] filmic_byte(input logic signed [IN_W-1:0] lin);
    logic [AW-1:0] x;
    logic [AW-1:0] num;
    logic [AW-1:0] den;
    logic [AW-1:0] q;
    x   = lin[IN_W-1] ? '0 : AW'(lin[IN_W-2:0]);
    x   = (x > TOE) ? x - TOE : '0;
    num = x * (AW'(310) * x + AW'(25) * UNIT);
    den = x * (AW'(310) * x + AW'(85) * UNIT) + AW'(3) * UNIT * UNIT;
    q   = (AW'(255) * num) / den;
    return (q > AW'(255)) ? {QW{1'b1}} : q[QW-1:0];
  endfunction

  task automatic note_failure(input string what, input rgb8_t want, input rgb8_t got);
    if (errors < 10)
      $display("%0t: %s: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d", $realtime,
               what, want.red, want.green, want.blue, got.red, got.green, got.blue);
    errors = errors + 1;
  endtask

  initial begin
    errors  = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    rgb8_t got;
    rgb8_t want;
    if (rst_n) begin
      if (in_px.valid && in_px.ready)
        expected_px.push_back('{filmic_byte(in_px.red_linear),
                                filmic_byte(in_px.green_linear),
                                filmic_byte(in_px.blue_linear)});
      if (out_px.valid && out_px.ready) begin
        got = '{out_px.red_byte, out_px.green_byte, out_px.blue_byte};
        if (expected_px.size() == 0) begin
          note_failure("unexpected word", '0, got);
        end else begin
          want = expected_px.pop_front();
          if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue)
            note_failure("pixel mismatch", want, got);
        end
      end
      pending = expected_px.size();
    end
  end

endmodule

`default_nettype wire

// ===== test/tb_filmic_tonemap_rgb8.sv =====
// ---------------------------------------------------------------------------
// tb_filmic_tonemap_rgb8
// Drives HDR pixels into the filmic tone mapper with random gaps and random
// output back-pressure, including one long output stall, while tonemap_check
// predicts and compares every RGB8 word.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_filmic_tonemap_rgb8;
  import ftm_pkg::*;

  localparam int STALL_CYCLES = 64;
  localparam int DRAIN_CYCLES = 30;

  logic clk;
  logic rst_n;
  logic quiet;
  logic burst;
  logic squeeze;
  logic squeezed;
  int   err_cnt;
  int   pending_cnt;

  ftm_in_if  in_px();
  ftm_out_if out_px();

  filmic_tonemap_rgb8 u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_px  (in_px),
    .out_px (out_px)
  );

  tonemap_check u_check (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_px   (in_px),
    .out_px  (out_px),
    .errors  (err_cnt),
    .pending (pending_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // mostly back-to-back, some short gaps, a few long ones
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic signed [IN_W-1:0] corner_value(input int k);
    case (k)
      0:       return IN_W'(0);
      1:       return IN_W'(-1);
      2:       return {1'b1, {(IN_W-1){1'b0}}};
      3:       return {1'b0, {(IN_W-1){1'b1}}};
      4:       return IN_W'(1);
      5:       return IN_W'(261);
      6:       return IN_W'(262);
      7:       return IN_W'(263);
      8:       return IN_W'(264);
      9:       return IN_W'(1) << INPUT_FRAC_BITS;
      10:      return IN_W'(1) << (INPUT_FRAC_BITS - 1);
      default: return IN_W'(1) << (IN_W - 2);
    endcase
  endfunction

  function automatic logic signed [IN_W-1:0] rand_channel();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1:    return IN_W'($urandom);
      2:       return IN_W'($urandom_range(0, 600));
      8:       return IN_W'($urandom_range(0, (1 << (IN_W - 1)) - 1));
      9:       return IN_W'(0 - $urandom_range(1, 1 << (IN_W - 1)));
      default: return IN_W'($urandom_range(0, 8 << INPUT_FRAC_BITS));
    endcase
  endfunction

  task automatic send_pixel(input logic signed [IN_W-1:0] r,
                            input logic signed [IN_W-1:0] g,
                            input logic signed [IN_W-1:0] b);
    int gap;
    gap = burst ? 0 : pick_gap();
    if (gap > 0) begin
      in_px.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_px.valid        <= 1'b1;
    in_px.red_linear   <= r;
    in_px.green_linear <= g;
    in_px.blue_linear  <= b;
    @(posedge clk);
    while (!in_px.ready) @(posedge clk);
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++)
      send_pixel(rand_channel(), rand_channel(), rand_channel());
  endtask

  // stimulus and verdict
  initial begin
    rst_n              = 1'b0;
    quiet              = 1'b0;
    burst              = 1'b0;
    squeeze            = 1'b0;
    in_px.valid        = 1'b0;
    in_px.red_linear   = '0;
    in_px.green_linear = '0;
    in_px.blue_linear  = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int k = 0; k < 12; k++)
      send_pixel(corner_value(k), corner_value(k), corner_value(k));
    for (int k = 0; k < 12; k++)
      send_pixel(corner_value(k), corner_value((k + 3) % 12), corner_value((k + 7) % 12));

    send_random(450);

    // full-rate burst while the receiver holds off: fill the pipe, stall input
    burst   = 1'b1;
    squeeze = 1'b1;
    send_random(100);
    burst   = 1'b0;

    quiet = 1'b1;
    send_random(200);
    quiet = 1'b0;
    send_random(200);

    in_px.valid <= 1'b0;
    @(posedge clk);
    wait (pending_cnt == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0 && pending_cnt == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  // output back-pressure
  initial begin
    int n;
    squeezed     = 1'b0;
    out_px.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (squeeze && !squeezed) begin
        out_px.ready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
        squeezed = 1'b1;
      end
      n = pick_gap();
      if (n > 0) begin
        out_px.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_px.ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+sv
sv/ftm_pkg.sv
sv/ftm_if.sv
sv/ftm_ctrl.sv
sv/ftm_curve.sv
sv/ftm_div.sv
sv/filmic_tonemap_rgb8.sv
sv/ftm_checker.sv
test/tonemap_check.sv
test/tb_filmic_tonemap_rgb8.sv
